@@ rtl/ryt_pkg.sv @@
// shared constants, codes and types for the rgb to yv12 tile converter
package ryt_pkg;

   localparam int TILE_SIZE_DEF = 8;
   localparam int MAX_DIM_DEF   = 4096;

   localparam int COLOR_W    = 8;
   localparam int ADDR_W     = 25;
   localparam int DATA_W     = 8;
   localparam int PLANE_W    = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam logic [CSR_DATA_W-1:0] FRAME_WIDTH_RST  = 13'd640;
   localparam logic [CSR_DATA_W-1:0] FRAME_HEIGHT_RST = 13'd480;

   // q16 color coefficients
   localparam int CQ_W  = 24;
   localparam int SUM_W = 27;
   localparam logic [15:0] Q16_Y_R  = 16'd19595;
   localparam logic [15:0] Q16_Y_G  = 16'd38470;
   localparam logic [15:0] Q16_Y_B  = 16'd7471;
   localparam logic [15:0] Q16_HALF = 16'd32768;
   localparam logic [15:0] Q16_U_R  = 16'd11056;
   localparam logic [15:0] Q16_U_G  = 16'd21712;
   localparam logic [15:0] Q16_V_G  = 16'd27440;
   localparam logic [15:0] Q16_V_B  = 16'd5328;
   localparam logic [CQ_W-1:0] Q16_OFFSET = 24'h80_0000;

   typedef enum logic [PLANE_W-1:0] {
      PLANE_Y = 2'd0,
      PLANE_U = 2'd1,
      PLANE_V = 2'd2
   } plane_type;

   typedef struct packed {
      logic in_img;
      logic chroma_en;
      logic group_start;
      logic frame_last;
   } pos_flags_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
      plane_type         plane;
   } beat_type;

   // slot 0 luma, slot 1 u, slot 2 v
   typedef struct packed {
      beat_type [2:0] beat;
      logic [2:0]     mask;
      logic           frame_last;
   } bundle_type;

endpackage

@@ rtl/ryt_if.sv @@
// valid/ready channel interfaces for pixels, write beats and register writes
interface ryt_req_if;
   logic                        valid;
   logic                        ready;
   logic [ryt_pkg::COLOR_W-1:0] red;
   logic [ryt_pkg::COLOR_W-1:0] green;
   logic [ryt_pkg::COLOR_W-1:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

interface ryt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ryt_pkg::ADDR_W-1:0]  write_addr;
   logic [ryt_pkg::DATA_W-1:0]  write_data;
   logic [ryt_pkg::PLANE_W-1:0] plane;
   logic                        last_of_item;
   logic                        frame_done;

   modport source (output valid, write_addr, write_data, plane, last_of_item, frame_done,
                   input ready);
   modport sink   (input valid, write_addr, write_data, plane, last_of_item, frame_done,
                   output ready);
endinterface

interface ryt_csr_if;
   logic                           valid;
   logic                           ready;
   logic [ryt_pkg::CSR_IDX_W-1:0]  index;
   logic [ryt_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/ryt_walker.sv @@
// tile order position counters and the input pixel register
module ryt_walker #(
   parameter int TILE_SIZE = ryt_pkg::TILE_SIZE_DEF,
   parameter int MAX_DIM   = ryt_pkg::MAX_DIM_DEF,
   localparam int DIM_W    = $clog2(MAX_DIM + 1),
   localparam int HALF     = (TILE_SIZE + 1) / 2,
   localparam int K_W      = (HALF > 1) ? $clog2(HALF) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   ryt_req_if.sink                     req_ch,
   input  logic [DIM_W-1:0]            frame_w,
   input  logic [DIM_W-1:0]            frame_h,
   input  logic                        advance,
   output logic                        item_valid,
   output ryt_pkg::pos_flags_type      item_flags,
   output logic [ryt_pkg::COLOR_W-1:0] item_red,
   output logic [ryt_pkg::COLOR_W-1:0] item_green,
   output logic [ryt_pkg::COLOR_W-1:0] item_blue,
   output logic [DIM_W-1:0]            item_ip,
   output logic [DIM_W-1:0]            item_jp,
   output logic [K_W-1:0]              item_k
);
   import ryt_pkg::*;

   localparam int TW    = $clog2(TILE_SIZE);
   localparam int POS_W = DIM_W + 1;

   logic [TW-1:0]    x_ff, x_in, y_ff, y_in;
   logic [DIM_W-1:0] col_ff, col_in, row_ff, row_in;
   logic             valid_ff, valid_in;
   pos_flags_type    flags_ff, flags_in;
   logic [COLOR_W-1:0] red_ff, green_ff, blue_ff;
   logic [DIM_W-1:0] ip_ff, jp_ff;
   logic [K_W-1:0]   k_ff;

   logic [POS_W-1:0] ip_full, jp_full;
   logic             accept, x_last, y_last, col_end, row_end;

   assign ip_full = POS_W'(col_ff) + POS_W'(x_ff);
   assign jp_full = POS_W'(row_ff) + POS_W'(y_ff);
   assign x_last  = (x_ff == TW'(TILE_SIZE - 1));
   assign y_last  = (y_ff == TW'(TILE_SIZE - 1));
   // last tile column or row once the next base reaches the image edge
   assign col_end = (POS_W'(col_ff) + POS_W'(TILE_SIZE)) >= POS_W'(frame_w);
   assign row_end = (POS_W'(row_ff) + POS_W'(TILE_SIZE)) >= POS_W'(frame_h);

   assign req_ch.ready = !valid_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      flags_in.in_img      = (ip_full < POS_W'(frame_w)) && (jp_full < POS_W'(frame_h));
      flags_in.chroma_en   = x_ff[0] && y_ff[0] &&
                             ((ip_full - 1'b1) < POS_W'(frame_w)) &&
                             ((jp_full - 1'b1) < POS_W'(frame_h));
      flags_in.group_start = !x_ff[0] && !y_ff[0];
      flags_in.frame_last  = x_last && y_last && col_end && row_end;

      valid_in = accept || (valid_ff && !advance);
      x_in   = x_ff;
      y_in   = y_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (flags_in.frame_last) begin
            x_in   = '0;
            y_in   = '0;
            col_in = '0;
            row_in = '0;
         end else if (!y_last) begin
            y_in = y_ff + 1'b1;
         end else begin
            y_in = '0;
            if (!x_last) begin
               x_in = x_ff + 1'b1;
            end else begin
               x_in = '0;
               if (!row_end) begin
                  row_in = DIM_W'(POS_W'(row_ff) + POS_W'(TILE_SIZE));
               end else begin
                  row_in = '0;
                  col_in = col_end ? '0 : DIM_W'(POS_W'(col_ff) + POS_W'(TILE_SIZE));
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff     <= '0;
         y_ff     <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         valid_ff <= valid_in;
      end
   end

   // out of image positions are black
   always_ff @(posedge clock) begin
      if (accept) begin
         flags_ff <= flags_in;
         red_ff   <= flags_in.in_img ? req_ch.red   : '0;
         green_ff <= flags_in.in_img ? req_ch.green : '0;
         blue_ff  <= flags_in.in_img ? req_ch.blue  : '0;
         ip_ff    <= DIM_W'(ip_full);
         jp_ff    <= DIM_W'(jp_full);
         k_ff     <= K_W'(y_ff >> 1);
      end
   end

   assign item_valid = valid_ff;
   assign item_flags = flags_ff;
   assign item_red   = red_ff;
   assign item_green = green_ff;
   assign item_blue  = blue_ff;
   assign item_ip    = ip_ff;
   assign item_jp    = jp_ff;
   assign item_k     = k_ff;

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && flags_in.frame_last |=> x_ff == '0 && y_ff == '0 && col_ff == '0 && row_ff == '0)
      else $error("counters not cleared after last tile position");

   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !advance |=> valid_ff && $stable(ip_ff) && $stable(jp_ff))
      else $error("held pixel changed before it was converted");

   a_base_range: assert property (@(posedge clock) disable iff (reset)
      POS_W'(col_ff) < POS_W'(MAX_DIM) && POS_W'(row_ff) < POS_W'(MAX_DIM))
      else $error("tile base out of range");

endmodule

@@ rtl/ryt_convert.sv @@
// color conversion, chroma group sums and write address generation
module ryt_convert #(
   parameter int TILE_SIZE = ryt_pkg::TILE_SIZE_DEF,
   parameter int MAX_DIM   = ryt_pkg::MAX_DIM_DEF,
   localparam int DIM_W    = $clog2(MAX_DIM + 1),
   localparam int HALF     = (TILE_SIZE + 1) / 2,
   localparam int K_W      = (HALF > 1) ? $clog2(HALF) : 1
) (
   input  logic                        clock,
   input  logic [DIM_W-1:0]            frame_w,
   input  logic [DIM_W-1:0]            frame_h,
   input  logic                        load,
   input  ryt_pkg::pos_flags_type      item_flags,
   input  logic [ryt_pkg::COLOR_W-1:0] item_red,
   input  logic [ryt_pkg::COLOR_W-1:0] item_green,
   input  logic [ryt_pkg::COLOR_W-1:0] item_blue,
   input  logic [DIM_W-1:0]            item_ip,
   input  logic [DIM_W-1:0]            item_jp,
   input  logic [K_W-1:0]              item_k,
   output ryt_pkg::bundle_type         bundle
);
   import ryt_pkg::*;

   localparam int ACC_W = (2 * DIM_W + 2 > ADDR_W) ? 2 * DIM_W + 2 : ADDR_W;

   function automatic logic [DATA_W-1:0] luma(input logic [COLOR_W-1:0] r,
                                              input logic [COLOR_W-1:0] g,
                                              input logic [COLOR_W-1:0] b);
      logic [CQ_W-1:0] acc;
      acc = CQ_W'(Q16_Y_R) * CQ_W'(r) + CQ_W'(Q16_Y_G) * CQ_W'(g) +
            CQ_W'(Q16_Y_B) * CQ_W'(b);
      return acc[CQ_W-1:16];
   endfunction

   function automatic logic [CQ_W-1:0] chroma_u(input logic [COLOR_W-1:0] r,
                                                input logic [COLOR_W-1:0] g,
                                                input logic [COLOR_W-1:0] b);
      return Q16_OFFSET + CQ_W'(Q16_HALF) * CQ_W'(b) - CQ_W'(Q16_U_R) * CQ_W'(r) -
             CQ_W'(Q16_U_G) * CQ_W'(g);
   endfunction

   function automatic logic [CQ_W-1:0] chroma_v(input logic [COLOR_W-1:0] r,
                                                input logic [COLOR_W-1:0] g,
                                                input logic [COLOR_W-1:0] b);
      return Q16_OFFSET + CQ_W'(Q16_HALF) * CQ_W'(r) - CQ_W'(Q16_V_G) * CQ_W'(g) -
             CQ_W'(Q16_V_B) * CQ_W'(b);
   endfunction

   logic [SUM_W-1:0] u_sum_ff [HALF];
   logic [SUM_W-1:0] v_sum_ff [HALF];
   logic [SUM_W-1:0] u_sum_in, v_sum_in;
   logic [ACC_W-1:0] area_ff;

   logic [DIM_W-1:0] cx, cy;
   logic [ACC_W-1:0] luma_addr, cidx, u_addr, v_addr;

   // a group's first pixel restarts its sum
   assign u_sum_in = (item_flags.group_start ? '0 : u_sum_ff[item_k]) +
                     SUM_W'(chroma_u(item_red, item_green, item_blue));
   assign v_sum_in = (item_flags.group_start ? '0 : v_sum_ff[item_k]) +
                     SUM_W'(chroma_v(item_red, item_green, item_blue));

   always_ff @(posedge clock) begin
      if (load) begin
         u_sum_ff[item_k] <= u_sum_in;
         v_sum_ff[item_k] <= v_sum_in;
      end
   end

   // plane size follows the registers; user keeps it stable for pixels
   always_ff @(posedge clock) begin
      area_ff <= ACC_W'(frame_w) * ACC_W'(frame_h);
   end

   assign cx        = DIM_W'(item_ip - 1'b1) >> 1;
   assign cy        = DIM_W'(item_jp - 1'b1) >> 1;
   assign luma_addr = ACC_W'(item_jp) * ACC_W'(frame_w) + ACC_W'(item_ip);
   assign cidx      = ACC_W'(cy) * ACC_W'(frame_w >> 1) + ACC_W'(cx);
   assign u_addr    = area_ff + cidx;
   assign v_addr    = area_ff + (area_ff >> 2) + cidx;

   always_comb begin
      bundle.beat[0].addr  = luma_addr[ADDR_W-1:0];
      bundle.beat[0].data  = luma(item_red, item_green, item_blue);
      bundle.beat[0].plane = PLANE_Y;
      bundle.beat[1].addr  = u_addr[ADDR_W-1:0];
      bundle.beat[1].data  = u_sum_in[SUM_W-2 -: DATA_W];
      bundle.beat[1].plane = PLANE_U;
      bundle.beat[2].addr  = v_addr[ADDR_W-1:0];
      bundle.beat[2].data  = v_sum_in[SUM_W-2 -: DATA_W];
      bundle.beat[2].plane = PLANE_V;
      bundle.mask          = {item_flags.chroma_en, item_flags.chroma_en, item_flags.in_img};
      bundle.frame_last    = item_flags.frame_last;
   end

endmodule

@@ rtl/ryt_emit.sv @@
// result register that sends one pixel's luma, u and v writes in order
module ryt_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  ryt_pkg::bundle_type bundle_in,
   output logic                load,
   ryt_rsp_if.source           rsp_ch
);
   import ryt_pkg::*;

   bundle_type bundle_ff;
   logic [2:0] rem_ff, rem_in;
   logic [2:0] clr;
   beat_type   cur;
   logic       fire, free;

   always_comb begin
      cur = bundle_ff.beat[2];
      clr = 3'b100;
      if (rem_ff[0]) begin
         cur = bundle_ff.beat[0];
         clr = 3'b001;
      end else if (rem_ff[1]) begin
         cur = bundle_ff.beat[1];
         clr = 3'b010;
      end
   end

   assign fire = rsp_ch.valid && rsp_ch.ready;
   // free when nothing is pending or the last pending beat goes out this cycle
   assign free = (rem_ff == 3'b000) || (fire && $onehot(rem_ff));
   assign load = item_valid && free;

   always_comb begin
      rem_in = rem_ff;
      if (load) begin
         rem_in = bundle_in.mask;
      end else if (fire) begin
         rem_in = rem_ff & ~clr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 3'b000;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bundle_ff <= bundle_in;
      end
   end

   assign rsp_ch.valid        = (rem_ff != 3'b000);
   assign rsp_ch.write_addr   = cur.addr;
   assign rsp_ch.write_data   = cur.data;
   assign rsp_ch.plane        = cur.plane;
   assign rsp_ch.last_of_item = $onehot(rem_ff);
   assign rsp_ch.frame_done   = bundle_ff.frame_last;

   a_uv_pair: assert property (@(posedge clock) disable iff (reset)
      rem_ff[1] |-> rem_ff[2])
      else $error("u beat pending without its v beat");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> rem_ff == 3'b000 || (fire && $onehot(rem_ff)))
      else $error("new pixel loaded over pending beats");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load && bundle_in.mask != 3'b000 |=> rsp_ch.valid)
      else $error("loaded writes not presented");

endmodule

@@ rtl/rgb_to_yv12_tile_converter.sv @@
// top level: rgb pixels in 8x8 tile order to planar yv12 byte writes
// a pixel beat is held in the walker input register, then in the emit result register
// throughput: one pixel per cycle while each pixel makes at most one write and the write
//   port is ready; a pixel closing a 2x2 group makes up to three writes on the one write
//   port and stalls the input until its writes are out
// reset: position counters and pipeline cleared, frame size 640 x 480
module rgb_to_yv12_tile_converter #(
   parameter int TILE_SIZE = ryt_pkg::TILE_SIZE_DEF,
   parameter int MAX_DIM   = ryt_pkg::MAX_DIM_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ryt_req_if.sink   req_ch,
   ryt_rsp_if.source rsp_ch,
   ryt_csr_if.sink   csr_ch
);
   import ryt_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int HALF  = (TILE_SIZE + 1) / 2;
   localparam int K_W   = (HALF > 1) ? $clog2(HALF) : 1;
   localparam int CMP_W = ((DIM_W > CSR_DATA_W) ? DIM_W : CSR_DATA_W) + 1;

   // sizes beyond the maximum are clamped for tiling and addressing
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CSR_DATA_W-1:0] d);
      return (CMP_W'(d) > CMP_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(d);
   endfunction

   logic [DIM_W-1:0] frame_w_ff, frame_h_ff;
   logic             csr_fire;

   logic               item_valid, load;
   pos_flags_type      item_flags;
   logic [COLOR_W-1:0] item_red, item_green, item_blue;
   logic [DIM_W-1:0]   item_ip, item_jp;
   logic [K_W-1:0]     item_k;
   bundle_type         bundle;

   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid && csr_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_w_ff <= clamp_dim(FRAME_WIDTH_RST);
         frame_h_ff <= clamp_dim(FRAME_HEIGHT_RST);
      end else if (csr_fire) begin
         unique case (csr_ch.index)
            CSR_FRAME_WIDTH:  frame_w_ff <= clamp_dim(csr_ch.data);
            CSR_FRAME_HEIGHT: frame_h_ff <= clamp_dim(csr_ch.data);
            default: ;
         endcase
      end
   end

   ryt_walker #(
      .TILE_SIZE (TILE_SIZE),
      .MAX_DIM   (MAX_DIM)
   ) u_walker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .frame_w    (frame_w_ff),
      .frame_h    (frame_h_ff),
      .advance    (load),
      .item_valid (item_valid),
      .item_flags (item_flags),
      .item_red   (item_red),
      .item_green (item_green),
      .item_blue  (item_blue),
      .item_ip    (item_ip),
      .item_jp    (item_jp),
      .item_k     (item_k)
   );

   ryt_convert #(
      .TILE_SIZE (TILE_SIZE),
      .MAX_DIM   (MAX_DIM)
   ) u_convert (
      .clock      (clock),
      .frame_w    (frame_w_ff),
      .frame_h    (frame_h_ff),
      .load       (load),
      .item_flags (item_flags),
      .item_red   (item_red),
      .item_green (item_green),
      .item_blue  (item_blue),
      .item_ip    (item_ip),
      .item_jp    (item_jp),
      .item_k     (item_k),
      .bundle     (bundle)
   );

   ryt_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .bundle_in  (bundle),
      .load       (load),
      .rsp_ch     (rsp_ch)
   );

endmodule

@@ tb/rgb_to_yv12_tile_converter_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench: tile-ordered rgb pixels in, yv12 plane writes predicted and compared
module rgb_to_yv12_tile_converter_tb;
   import ryt_pkg::*;

   localparam int TILE = TILE_SIZE_DEF;
   localparam int HALF_TILE = (TILE + 1) / 2;
   localparam int unsigned DIM_CAP = MAX_DIM_DEF;

   // q16 weights of the jfif conversion
   localparam int unsigned LUMA_R_Q16 = 19595;
   localparam int unsigned LUMA_G_Q16 = 38470;
   localparam int unsigned LUMA_B_Q16 = 7471;
   localparam int unsigned CHROMA_HALF_Q16 = 32768;
   localparam int unsigned CB_R_Q16 = 11056;
   localparam int unsigned CB_G_Q16 = 21712;
   localparam int unsigned CR_G_Q16 = 27440;
   localparam int unsigned CR_B_Q16 = 5328;
   localparam int unsigned CHROMA_BIAS_Q16 = 128 << 16;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int STALL_LIMIT = 4000;

   // {red, green, blue}: each 2x2 group of the first two columns is one solid color
   localparam logic [23:0] OPENING_PIXELS [24] = '{
      24'h0000FF, 24'h0000FF, 24'hFF0000, 24'hFF0000,
      24'hFFFF00, 24'hFFFF00, 24'h00FFFF, 24'h00FFFF,
      24'h0000FF, 24'h0000FF, 24'hFF0000, 24'hFF0000,
      24'hFFFF00, 24'hFFFF00, 24'h00FFFF, 24'h00FFFF,
      24'hFFFFFF, 24'h000000, 24'h00FF00, 24'hFF00FF,
      24'h808080, 24'h7F7F7F, 24'h010204, 24'hFEFDFB
   };

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
      plane_type         plane;
      logic              last_of_item;
      logic              frame_done;
   } yv12_write_t;

   class yv12_write_scoreboard;
      yv12_write_t writes_due[$];
      logic [CSR_DATA_W-1:0] frame_w;
      logic [CSR_DATA_W-1:0] frame_h;
      int unsigned tile_col, tile_row, col_in_tile, row_in_tile;
      logic [SUM_W-1:0] cb_sum [HALF_TILE];
      logic [SUM_W-1:0] cr_sum [HALF_TILE];
      int unsigned pixels, visible_pixels, writes_checked, mismatches;

      function new();
         frame_w = FRAME_WIDTH_RST;
         frame_h = FRAME_HEIGHT_RST;
         tile_col = 0;
         tile_row = 0;
         col_in_tile = 0;
         row_in_tile = 0;
         foreach (cb_sum[i]) begin
            cb_sum[i] = '0;
            cr_sum[i] = '0;
         end
         pixels = 0;
         visible_pixels = 0;
         writes_checked = 0;
         mismatches = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_FRAME_WIDTH) frame_w = val;
         else if (idx == CSR_FRAME_HEIGHT) frame_h = val;
      endfunction

      function bit at_frame_start();
         return tile_col == 0 && tile_row == 0 && col_in_tile == 0 && row_in_tile == 0;
      endfunction

      function int unsigned due();
         return writes_due.size();
      endfunction

      function void note_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
         int unsigned w, h, ntx, nty, px, py, r, g, b, luma, cb_q, cr_q, k, area, cidx;
         bit inside_img, x_odd, y_odd, frame_last;
         yv12_write_t beats[$];
         yv12_write_t wr;
         w = (frame_w > DIM_CAP) ? DIM_CAP : frame_w;
         h = (frame_h > DIM_CAP) ? DIM_CAP : frame_h;
         ntx = (w + TILE - 1) / TILE;
         nty = (h + TILE - 1) / TILE;
         if (ntx == 0) ntx = 1;
         if (nty == 0) nty = 1;
         px = tile_col * TILE + col_in_tile;
         py = tile_row * TILE + row_in_tile;
         inside_img = px < w && py < h;
         // outside the image the pixel counts as black
         r = inside_img ? red : 0;
         g = inside_img ? green : 0;
         b = inside_img ? blue : 0;
         luma = (LUMA_R_Q16 * r + LUMA_G_Q16 * g + LUMA_B_Q16 * b) >> 16;
         cb_q = CHROMA_BIAS_Q16 + CHROMA_HALF_Q16 * b - CB_R_Q16 * r - CB_G_Q16 * g;
         cr_q = CHROMA_BIAS_Q16 + CHROMA_HALF_Q16 * r - CR_G_Q16 * g - CR_B_Q16 * b;
         k = (row_in_tile >> 1) % HALF_TILE;
         x_odd = col_in_tile[0];
         y_odd = row_in_tile[0];
         frame_last = col_in_tile == TILE - 1 && row_in_tile == TILE - 1 &&
                      tile_col + 1 >= ntx && tile_row + 1 >= nty;

         // top-left pixel of a group restarts its sums
         if (!x_odd && !y_odd) begin
            cb_sum[k] = cb_q[SUM_W-1:0];
            cr_sum[k] = cr_q[SUM_W-1:0];
         end else begin
            cb_sum[k] = cb_sum[k] + cb_q[SUM_W-1:0];
            cr_sum[k] = cr_sum[k] + cr_q[SUM_W-1:0];
         end

         if (inside_img) begin
            wr = '0;
            wr.addr = ADDR_W'(py * w + px);
            wr.data = DATA_W'(luma);
            wr.plane = PLANE_Y;
            beats.push_back(wr);
         end
         if (x_odd && y_odd && (px - 1) < w && (py - 1) < h) begin
            area = w * h;
            cidx = ((py - 1) / 2) * (w / 2) + (px - 1) / 2;
            wr = '0;
            wr.addr = ADDR_W'(area + cidx);
            wr.data = DATA_W'(cb_sum[k] >> 18);
            wr.plane = PLANE_U;
            beats.push_back(wr);
            wr.addr = ADDR_W'(area + area / 4 + cidx);
            wr.data = DATA_W'(cr_sum[k] >> 18);
            wr.plane = PLANE_V;
            beats.push_back(wr);
         end
         foreach (beats[i]) begin
            beats[i].frame_done = frame_last;
            beats[i].last_of_item = (i == beats.size() - 1);
            writes_due.push_back(beats[i]);
         end

         pixels++;
         if (inside_img) visible_pixels++;

         // scan order: y inner, x, tile row, tile column outer
         if (frame_last) begin
            tile_col = 0;
            tile_row = 0;
            col_in_tile = 0;
            row_in_tile = 0;
         end else if (row_in_tile + 1 < TILE) begin
            row_in_tile++;
         end else begin
            row_in_tile = 0;
            if (col_in_tile + 1 < TILE) begin
               col_in_tile++;
            end else begin
               col_in_tile = 0;
               if (tile_row + 1 < nty) begin
                  tile_row++;
               end else begin
                  tile_row = 0;
                  tile_col = (tile_col + 1 < ntx) ? tile_col + 1 : 0;
               end
            end
         end
      endfunction

      function void flag(bit has_want, yv12_write_t want, yv12_write_t got);
         mismatches++;
         if (mismatches <= 10) begin
            // fields shown as addr/data/plane/last/done
            if (has_want)
               $display("write mismatch: expected %h/%h/%0d/%b/%b, got %h/%h/%0d/%b/%b",
                        want.addr, want.data, want.plane, want.last_of_item,
                        want.frame_done, got.addr, got.data, got.plane,
                        got.last_of_item, got.frame_done);
            else
               $display("unexpected write: addr %h data %h plane %0d last %b done %b",
                        got.addr, got.data, got.plane, got.last_of_item, got.frame_done);
         end
      endfunction

      function void check_write(yv12_write_t got);
         yv12_write_t want;
         writes_checked++;
         if (writes_due.size() == 0) begin
            flag(1'b0, '0, got);
            return;
         end
         want = writes_due.pop_front();
         if (got.addr !== want.addr || got.data !== want.data || got.plane !== want.plane ||
             got.last_of_item !== want.last_of_item || got.frame_done !== want.frame_done)
            flag(1'b1, want, got);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   ryt_req_if req_ch ();
   ryt_rsp_if rsp_ch ();
   ryt_csr_if csr_ch ();

   rgb_to_yv12_tile_converter dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   yv12_write_scoreboard plane_writes;
   int burst_left = 0;
   int frame_settings = 0;
   int stall_cycles = 0;
   bit hold_off_req = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [7:0] rand_level();
      case ($urandom_range(0, 3))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
         repeat (gap) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.red <= r;
      req_ch.green <= g;
      req_ch.blue <= b;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      plane_writes.note_pixel(r, g, b);
      burst_left--;
   endtask

   task automatic send_pixels(input int count);
      repeat (count) send_pixel(rand_level(), rand_level(), rand_level());
   endtask

   task automatic finish_frame();
      do send_pixel(rand_level(), rand_level(), rand_level());
      while (!plane_writes.at_frame_start());
   endtask

   // stop offering, wait for every write, then let pixels without writes leave the pipe
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (plane_writes.due() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= val;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      plane_writes.set_reg(idx, val);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic set_frame(input logic [CSR_DATA_W-1:0] w, input logic [CSR_DATA_W-1:0] h);
      settle();
      csr_write(CSR_FRAME_WIDTH, w);
      csr_write(CSR_FRAME_HEIGHT, h);
      frame_settings++;
   endtask

   // write sink: a repeating stall pattern, and a long hold-off when one is requested
   initial begin
      bit [7:0] stall_pattern;
      int unsigned stall_step;
      rsp_ch.ready = 1'b0;
      stall_pattern = 8'hFF;
      stall_step = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else begin
            if (stall_step % 48 == 0)
               stall_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom()) | 8'h01;
            rsp_ch.ready <= stall_pattern[stall_step % 8];
            stall_step++;
         end
      end
   end

   always @(posedge clock) begin
      yv12_write_t got;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.addr = rsp_ch.write_addr;
         got.data = rsp_ch.write_data;
         got.plane = plane_type'(rsp_ch.plane);
         got.last_of_item = rsp_ch.last_of_item;
         got.frame_done = rsp_ch.frame_done;
         plane_writes.check_write(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
          (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("no beat on any channel for %0d cycles, %0d writes still due",
                  STALL_LIMIT, plane_writes.due());
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      plane_writes = new();
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.red = '0;
      req_ch.green = '0;
      req_ch.blue = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_FRAME_WIDTH;
      csr_ch.data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // solid-color groups at the chroma extremes, under the reset frame size
      foreach (OPENING_PIXELS[i])
         send_pixel(OPENING_PIXELS[i][23:16], OPENING_PIXELS[i][15:8], OPENING_PIXELS[i][7:0]);

      // shrink mid-frame so the last position is inside the image, with the sink
      // held off to back the block up
      set_frame(8, 8);
      hold_off_req = 1'b1;
      finish_frame();
      // oversized sizes saturate; chroma lands on high address bits
      set_frame(13'h1FFF, 5000);
      send_pixels(10);
      // zero width, then zero height: nothing is written
      set_frame(0, 3);
      send_pixels(6);
      set_frame(5, 0);
      send_pixels(6);
      // odd size: groups cut by the image edge, last position outside the image
      set_frame(3, 5);
      csr_write(CSR_UNMAPPED, 13'h1FFF);
      finish_frame();

      settle();
      $display("run covered %0d pixels (%0d inside the image) over %0d frame sizes",
               plane_writes.pixels, plane_writes.visible_pixels, frame_settings);
      $display("%0d plane writes checked, %0d mismatches",
               plane_writes.writes_checked, plane_writes.mismatches);
      if (plane_writes.mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

@@ rgb_to_yv12_tile_converter.f @@
rtl/ryt_pkg.sv
rtl/ryt_if.sv
rtl/ryt_walker.sv
rtl/ryt_convert.sv
rtl/ryt_emit.sv
rtl/rgb_to_yv12_tile_converter.sv
tb/rgb_to_yv12_tile_converter_tb.sv
